// ===== design/dotq_pkg.sv =====
// Package for the deadline-ordered timeout queue.
// Holds widths, operation/result/status codes and the item and result structs.
// No dependencies.
package dotq_pkg;

    localparam int TIMERS_DEF    = 16;
    localparam int TIME_BITS_DEF = 40;
    localparam int ID_W          = 16;
    localparam int DELAY_W       = 32;
    localparam int OCC_W         = 5;

    typedef enum logic [1:0] {
        FUNC_ADD    = 2'd0,
        FUNC_REMOVE = 2'd1,
        FUNC_TICK   = 2'd2,
        FUNC_NONE   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        KIND_ADD    = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_EXPIRE = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_NONE      = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0]         func;
        logic [ID_W-1:0]    subscriber_id;
        logic [DELAY_W-1:0] delay_ms;
    } in_item_t;

    typedef struct packed {
        logic [1:0]      kind;
        logic [1:0]      status;
        logic [ID_W-1:0] expired_id;
        logic [OCC_W-1:0] occupancy;
        logic            last;
    } result_t;

endpackage

// ===== design/dotq_if.sv =====
// Valid/ready channel interface carrying one payload of type PAYLOAD_T.
// Depends on nothing; payload type is supplied per instance.
interface dotq_if #(parameter type PAYLOAD_T = logic) ();
    logic     valid;
    logic     ready;
    PAYLOAD_T payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== design/deadline_ordered_timeout_queue_top.sv =====
// Deadline-ordered timeout queue top level; depends on dotq_pkg, dotq_if, dotq_ram.
// An add walks the table to its place and shifts later entries up; a remove walks
//   to the match and shifts later entries down; a tick reads, tests and removes the front.
// One item in flight; walks over the entry RAM (one read, one write port) set the rate.
// Reset: count and time clear at once; the RAM is not cleared (only entries
//   below the count are ever read).
module deadline_ordered_timeout_queue_top #(
    parameter int TIMERS    = dotq_pkg::TIMERS_DEF,
    parameter int TIME_BITS = dotq_pkg::TIME_BITS_DEF
) (
    input logic clk,
    input logic rst_n,
    dotq_if.sink   in_ch,
    dotq_if.source out_ch
);
    localparam int AW = $clog2(TIMERS);
    localparam int CW = $clog2(TIMERS + 1);
    localparam int EW = TIME_BITS + dotq_pkg::ID_W;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_FIND   = 8'b0000_0010,  // read entry idx
        S_CHECK  = 8'b0000_0100,  // compare read data
        S_SHIFT  = 8'b0000_1000,  // moving entries
        S_INS    = 8'b0001_0000,
        S_OUT    = 8'b0010_0000,
        S_TICKRD = 8'b0100_0000,
        S_TICKCK = 8'b1000_0000
    } state_t;

    state_t               state_reg, state_next;
    logic [TIME_BITS-1:0] time_reg, time_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [CW-1:0]        idx_reg, idx_next;
    logic [CW-1:0]        pos_reg, pos_next;           // insert position
    logic [1:0]           func_reg, func_next;
    logic [dotq_pkg::ID_W-1:0] id_reg, id_next;
    logic [TIME_BITS-1:0] dl_reg, dl_next;
    logic                 shift_up_reg, shift_up_next; // 1: insert shift, 0: delete shift
    logic                 shrd_reg, shrd_next;         // shift read pending
    logic                 any_reg, any_next;           // tick holds an unsent expiry
    dotq_pkg::result_t    res_reg, res_next;
    logic                 ovalid_reg, ovalid_next;

    logic                 we;
    logic [AW-1:0]        waddr, raddr;
    logic [EW-1:0]        wdata, rdata;
    logic [TIME_BITS-1:0] rd_dl;
    logic [dotq_pkg::ID_W-1:0] rd_id;

    dotq_ram #(.DEPTH(TIMERS), .WIDTH(EW)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    assign rd_dl = rdata[EW-1 -: TIME_BITS];
    assign rd_id = rdata[dotq_pkg::ID_W-1:0];

    assign in_ch.ready      = (state_reg == S_IDLE) && !ovalid_reg;
    assign out_ch.valid     = ovalid_reg;
    assign out_ch.payload   = res_reg;

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        time_next     = time_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        pos_next      = pos_reg;
        func_next     = func_reg;
        id_next       = id_reg;
        dl_next       = dl_reg;
        shift_up_next = shift_up_reg;
        shrd_next     = shrd_reg;
        any_next      = any_reg;
        res_next      = res_reg;
        ovalid_next   = ovalid_reg;
        we            = 1'b0;
        waddr         = idx_reg[AW-1:0];
        wdata         = rdata;
        raddr         = idx_reg[AW-1:0];

        if (ovalid_reg && out_ch.ready)
        begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid && !ovalid_reg)
                begin
                    func_next = in_ch.payload.func;
                    id_next   = in_ch.payload.subscriber_id;
                    dl_next   = time_reg + TIME_BITS'(in_ch.payload.delay_ms);
                    idx_next  = '0;
                    any_next  = 1'b0;
                    case (in_ch.payload.func)
                        dotq_pkg::FUNC_ADD:
                        begin
                            if (count_reg == CW'(TIMERS))
                            begin
                                res_next = '{dotq_pkg::KIND_ADD, dotq_pkg::ST_FULL,
                                    in_ch.payload.subscriber_id,
                                    dotq_pkg::OCC_W'(count_reg), 1'b1};
                                ovalid_next = 1'b1;
                            end
                            else
                            begin
                                state_next = S_FIND;
                            end
                        end
                        dotq_pkg::FUNC_REMOVE:
                        begin
                            state_next = S_FIND;
                        end
                        dotq_pkg::FUNC_TICK:
                        begin
                            time_next  = time_reg + TIME_BITS'(1);
                            state_next = S_TICKRD;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            // issue read of entry idx, or finish the search at the end
            S_FIND:
            begin
                if (idx_reg == count_reg)
                begin
                    if (func_reg == dotq_pkg::FUNC_ADD)
                    begin
                        state_next = S_INS;
                    end
                    else
                    begin
                        res_next = '{dotq_pkg::KIND_REMOVE, dotq_pkg::ST_NOT_FOUND,
                            id_reg, dotq_pkg::OCC_W'(count_reg), 1'b1};
                        state_next = S_OUT;
                    end
                end
                else
                begin
                    state_next = S_CHECK;
                end
            end

            S_CHECK:
            begin
                if (func_reg == dotq_pkg::FUNC_ADD)
                begin
                    if (rd_dl <= dl_reg)
                    begin
                        idx_next   = idx_reg + CW'(1);
                        state_next = S_FIND;
                    end
                    else
                    begin
                        // shift entries [idx, count) up, walking from the top
                        shift_up_next = 1'b1;
                        shrd_next     = 1'b0;
                        state_next    = S_SHIFT;
                        pos_next      = idx_reg;
                        idx_next      = count_reg - CW'(1);
                    end
                end
                else if (rd_id == id_reg)
                begin
                    shift_up_next = 1'b0;
                    shrd_next     = 1'b0;
                    idx_next      = idx_reg + CW'(1);
                    state_next    = S_SHIFT;
                end
                else
                begin
                    idx_next   = idx_reg + CW'(1);
                    state_next = S_FIND;
                end
            end

            // move one entry at a time: read it, then write it to its neighbor
            S_SHIFT:
            begin
                if (shift_up_reg)
                begin
                    if (!shrd_reg)
                    begin
                        shrd_next = 1'b1;
                    end
                    else
                    begin
                        we        = 1'b1;
                        waddr     = AW'(idx_reg + CW'(1));
                        shrd_next = 1'b0;
                        if (idx_reg == pos_reg)
                        begin
                            state_next = S_INS;
                        end
                        else
                        begin
                            idx_next = idx_reg - CW'(1);
                        end
                    end
                end
                else
                begin
                    if (idx_reg == count_reg)
                    begin
                        count_next = count_reg - CW'(1);
                        if (func_reg == dotq_pkg::FUNC_TICK)
                        begin
                            idx_next   = '0;
                            state_next = S_TICKRD;
                        end
                        else
                        begin
                            res_next = '{dotq_pkg::KIND_REMOVE, dotq_pkg::ST_OK,
                                id_reg, dotq_pkg::OCC_W'(count_reg - CW'(1)), 1'b1};
                            state_next = S_OUT;
                        end
                    end
                    else if (!shrd_reg)
                    begin
                        shrd_next = 1'b1;
                    end
                    else
                    begin
                        we        = 1'b1;
                        waddr     = AW'(idx_reg - CW'(1));
                        shrd_next = 1'b0;
                        idx_next  = idx_reg + CW'(1);
                    end
                end
            end

            // write new entry at idx
            S_INS:
            begin
                we         = 1'b1;
                wdata      = {dl_reg, id_reg};
                count_next = count_reg + CW'(1);
                res_next   = '{dotq_pkg::KIND_ADD, dotq_pkg::ST_OK, id_reg,
                    dotq_pkg::OCC_W'(count_reg + CW'(1)), 1'b1};
                state_next = S_OUT;
            end

            S_OUT:
            begin
                if (!ovalid_reg)
                begin
                    ovalid_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end

            // tick: read front entry
            S_TICKRD:
            begin
                raddr = '0;
                if (ovalid_reg)
                begin
                    state_next = S_TICKRD;
                end
                else if (count_reg == '0)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_TICKCK;
                end
            end

            S_TICKCK:
            begin
                if (rd_dl <= time_reg)
                begin
                    if (any_reg)
                    begin
                        // front is due, so the held expiry is not last: send it,
                        // then read the front again
                        ovalid_next = 1'b1;
                        any_next    = 1'b0;
                        state_next  = S_TICKRD;
                    end
                    else
                    begin
                        // hold result until we know if it is the last
                        res_next = '{dotq_pkg::KIND_EXPIRE, dotq_pkg::ST_OK, rd_id,
                            dotq_pkg::OCC_W'(count_reg - CW'(1)), 1'b0};
                        any_next      = 1'b1;
                        idx_next      = CW'(1);
                        shift_up_next = 1'b0;
                        shrd_next     = 1'b0;
                        state_next    = S_SHIFT;
                    end
                end
                else
                begin
                    if (any_reg)
                    begin
                        res_next.last = 1'b1;
                        state_next    = S_OUT;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // tick ran out of entries: flush final pending result
        if (state_reg == S_TICKRD && !ovalid_reg && count_reg == '0 && any_reg)
        begin
            res_next.last = 1'b1;
            ovalid_next   = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            time_reg   <= '0;
            count_reg  <= '0;
            ovalid_reg <= 1'b0;
            any_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            time_reg   <= time_next;
            count_reg  <= count_next;
            ovalid_reg <= ovalid_next;
            any_reg    <= any_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        pos_reg      <= pos_next;
        func_reg     <= func_next;
        id_reg       <= id_next;
        dl_reg       <= dl_next;
        shift_up_reg <= shift_up_next;
        shrd_reg     <= shrd_next;
        res_reg      <= res_next;
    end

    // checks
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(TIMERS))
        else $error("count over capacity");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> !in_ch.ready)
        else $error("ready while busy");
    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        we |-> (CW'(waddr) <= count_reg))
        else $error("write beyond table");
endmodule

// ===== design/dotq_ram.sv =====
// Entry store: one sorted table of {deadline, owner}, with a registered (sync) read.
// Depends on nothing outside this file.
module dotq_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 56
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end
endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the deadline-ordered timeout queue.
// Depends on dotq_pkg, dotq_if and deadline_ordered_timeout_queue_top.
module tb_top;

    localparam int TIMERS       = dotq_pkg::TIMERS_DEF;
    localparam int TIME_BITS    = dotq_pkg::TIME_BITS_DEF;
    localparam int ID_W         = dotq_pkg::ID_W;
    localparam int DELAY_W      = dotq_pkg::DELAY_W;
    localparam int OCC_W        = dotq_pkg::OCC_W;
    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 200;

    logic clk;
    logic rst_n;

    dotq_if #(.PAYLOAD_T(dotq_pkg::in_item_t)) in_ch ();
    dotq_if #(.PAYLOAD_T(dotq_pkg::result_t))  out_ch ();

    deadline_ordered_timeout_queue_top #(
        .TIMERS    (TIMERS),
        .TIME_BITS (TIME_BITS)
    ) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // Shadow copy of the timeout table
    logic [TIME_BITS-1:0] now_ms;
    logic [TIME_BITS-1:0] due_at [TIMERS];
    logic [ID_W-1:0]      owner_of [TIMERS];
    int                   pending_cnt;

    dotq_pkg::result_t pending_results [$];
    int      err_cnt;
    int      items_sent;
    int      results_seen;
    int      expiries_seen;
    int      full_seen;
    int      not_found_seen;
    int      idle_cycles;
    bit      no_idle;

    // Clock
    initial clk = 1'b0;
    always #1 clk = ~clk;

    function automatic dotq_pkg::result_t make_result(dotq_pkg::kind_t k,
                                                      dotq_pkg::status_t s,
                                                      logic [ID_W-1:0] id, logic lst);
        dotq_pkg::result_t r;
        r.kind       = k;
        r.status     = s;
        r.expired_id = id;
        r.occupancy  = pending_cnt[OCC_W-1:0];
        r.last       = lst;
        return r;
    endfunction

    function automatic void drop_slot(int pos);
        int i;
        for (i = pos; i + 1 < pending_cnt; i++)
        begin
            due_at[i]   = due_at[i + 1];
            owner_of[i] = owner_of[i + 1];
        end
        pending_cnt--;
    endfunction

    // Work out the results one accepted item causes
    function automatic void predict_timeouts(dotq_pkg::in_item_t it);
        logic [TIME_BITS-1:0] dl;
        int                   pos;
        int                   i;
        int                   n;
        bit                   hit;
        logic [ID_W-1:0]      who;
        n   = 0;
        hit = 0;
        case (dotq_pkg::func_t'(it.func))
            dotq_pkg::FUNC_ADD:
            begin
                if (pending_cnt >= TIMERS)
                    pending_results.push_back(make_result(dotq_pkg::KIND_ADD,
                                                          dotq_pkg::ST_FULL,
                                                          it.subscriber_id, 1'b1));
                else
                begin
                    dl  = now_ms + TIME_BITS'(it.delay_ms);
                    pos = 0;
                    while (pos < pending_cnt && due_at[pos] <= dl)
                        pos++;
                    for (i = pending_cnt; i > pos; i--)
                    begin
                        due_at[i]   = due_at[i - 1];
                        owner_of[i] = owner_of[i - 1];
                    end
                    due_at[pos]   = dl;
                    owner_of[pos] = it.subscriber_id;
                    pending_cnt++;
                    pending_results.push_back(make_result(dotq_pkg::KIND_ADD,
                                                          dotq_pkg::ST_OK,
                                                          it.subscriber_id, 1'b1));
                end
            end
            dotq_pkg::FUNC_REMOVE:
            begin
                for (i = 0; i < pending_cnt && !hit; i++)
                begin
                    if (owner_of[i] == it.subscriber_id)
                    begin
                        drop_slot(i);
                        hit = 1;
                    end
                end
                pending_results.push_back(make_result(dotq_pkg::KIND_REMOVE,
                                                      hit ? dotq_pkg::ST_OK
                                                          : dotq_pkg::ST_NOT_FOUND,
                                                      it.subscriber_id, 1'b1));
            end
            dotq_pkg::FUNC_TICK:
            begin
                now_ms = now_ms + TIME_BITS'(1);
                while (pending_cnt > 0 && due_at[0] <= now_ms)
                begin
                    who = owner_of[0];
                    drop_slot(0);
                    pending_results.push_back(make_result(dotq_pkg::KIND_EXPIRE,
                                                          dotq_pkg::ST_OK, who, 1'b0));
                    n++;
                end
                if (n > 0)
                    pending_results[pending_results.size() - 1].last = 1'b1;
            end
            default: ;
        endcase
    endfunction

    // Send one item; valid stays high into the next item unless a gap is taken
    task automatic send_item(dotq_pkg::func_t f, logic [ID_W-1:0] id,
                             logic [DELAY_W-1:0] d);
        dotq_pkg::in_item_t it;
        it.func          = f;
        it.subscriber_id = id;
        it.delay_ms      = d;
        while (!no_idle && $urandom_range(99) < 35)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.payload <= it;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        predict_timeouts(it);
        items_sent++;
    endtask

    // Output side: check each transfer, then pick the next ready
    always @(posedge clk)
    begin
        dotq_pkg::result_t want;
        dotq_pkg::result_t got;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got = out_ch.payload;
            results_seen++;
            if (got.kind == dotq_pkg::KIND_EXPIRE)
                expiries_seen++;
            if (got.status == dotq_pkg::ST_FULL)
                full_seen++;
            if (got.status == dotq_pkg::ST_NOT_FOUND)
                not_found_seen++;
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: kind %0d id %0h", got.kind, got.expired_id);
                err_cnt++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.kind !== want.kind)
                begin
                    $error("kind: expected %0d, got %0d", want.kind, got.kind);
                    err_cnt++;
                end
                if (got.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    err_cnt++;
                end
                if (got.expired_id !== want.expired_id)
                begin
                    $error("expired_id: expected %0h, got %0h", want.expired_id,
                           got.expired_id);
                    err_cnt++;
                end
                if (got.occupancy !== want.occupancy)
                begin
                    $error("occupancy: expected %0d, got %0d", want.occupancy,
                           got.occupancy);
                    err_cnt++;
                end
                if (got.last !== want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, got.last);
                    err_cnt++;
                end
            end
        end
        out_ch.ready <= no_idle || ($urandom_range(99) >= 35);
    end

    // Watchdog: cycles without any transfer
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    // Add, remove hit and miss, immediate expiry, equal deadlines, unused code
    task automatic test_basic_ops();
        send_item(dotq_pkg::FUNC_ADD, 16'hFFFF, 32'd0);
        send_item(dotq_pkg::FUNC_ADD, 16'h0000, 32'd1);
        send_item(dotq_pkg::FUNC_ADD, 16'h1234, 32'd1);
        send_item(dotq_pkg::FUNC_ADD, 16'h5555, 32'hFFFF_FFFF);
        send_item(dotq_pkg::FUNC_REMOVE, 16'hAAAA, 32'hFFFF_FFFF);
        send_item(dotq_pkg::FUNC_NONE, 16'hFFFF, 32'hFFFF_FFFF);
        send_item(dotq_pkg::FUNC_TICK, 16'h0000, 32'd0);
        send_item(dotq_pkg::FUNC_TICK, 16'hFFFF, 32'd0);
        send_item(dotq_pkg::FUNC_TICK, 16'h0000, 32'd0);
        send_item(dotq_pkg::FUNC_REMOVE, 16'h5555, 32'd0);
    endtask

    // Fill the table, overflow it, then flush it with ticks
    task automatic test_table_full();
        int i;
        for (i = 0; i < TIMERS; i++)
            send_item(dotq_pkg::FUNC_ADD, ID_W'(i), DELAY_W'(i % 4));
        send_item(dotq_pkg::FUNC_ADD, 16'hBEEF, 32'd0);
        for (i = 0; i < 4; i++)
            send_item(dotq_pkg::FUNC_TICK, 16'h0000, 32'd0);
    endtask

    // Ticks, adds with mostly short delays, removes mostly of live ids, and the odd unused code
    task automatic test_random(int count);
        int               i;
        int               r;
        logic [ID_W-1:0]  id;
        logic [DELAY_W-1:0] d;
        for (i = 0; i < count; i++)
        begin
            no_idle = (i < 80);
            r = $urandom_range(99);
            id = ($urandom_range(3) == 0) ? ID_W'($urandom) : ID_W'($urandom_range(7));
            if (r < 35)
            begin
                d = ($urandom_range(19) == 0) ? DELAY_W'($urandom)
                                              : DELAY_W'($urandom_range(12));
                send_item(dotq_pkg::FUNC_ADD, id, d);
            end
            else if (r < 55)
            begin
                if (pending_cnt > 0 && $urandom_range(4) != 0)
                    id = owner_of[$urandom_range(pending_cnt - 1)];
                send_item(dotq_pkg::FUNC_REMOVE, id, DELAY_W'($urandom));
            end
            else if (r < 97)
                send_item(dotq_pkg::FUNC_TICK, id, DELAY_W'($urandom));
            else
                send_item(dotq_pkg::FUNC_NONE, id, DELAY_W'($urandom));
        end
        no_idle = 0;
    endtask

    initial
    begin
        rst_n         = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.payload = '0;
        out_ch.ready  = 1'b0;
        now_ms        = '0;
        pending_cnt   = 0;
        err_cnt       = 0;
        items_sent    = 0;
        results_seen  = 0;
        expiries_seen = 0;
        full_seen     = 0;
        not_found_seen = 0;
        idle_cycles   = 0;
        no_idle       = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_ops();
        test_table_full();
        test_random(370);
        in_ch.valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d items sent, %0d results checked (%0d expiries, %0d full, %0d not found)",
                 items_sent, results_seen, expiries_seen, full_seen, not_found_seen);
        if (err_cnt == 0 && pending_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== deadline_ordered_timeout_queue_top.f =====
design/dotq_pkg.sv
design/dotq_if.sv
design/dotq_ram.sv
design/deadline_ordered_timeout_queue_top.sv
tb/sv/tb_top.sv
